>>> hw/rtl/mbve_pkg.sv
// package: operation codes, item types and controller types for the bit-vector enumerator
package mbve_pkg;

    localparam int FIELD_W   = 32;
    localparam int AW_W      = 6;
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W     = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_VALUE  = 1'b0,
        CFG_ACTIVE_WIDTH = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_INC         = 4'd0,
        OP_DEC         = 4'd1,
        OP_LEARN_FLIP  = 4'd2,
        OP_LEARN_VALUE = 4'd3,
        OP_RESET_ALL   = 4'd4,
        OP_RESET_RIGHT = 4'd5,
        OP_RESET_LEFT  = 4'd6,
        OP_RESTART     = 4'd7,
        OP_READ        = 4'd8
    } op_t;

    typedef struct packed {
        logic [3:0]       operation;
        logic [IDX_W-1:0] bit_index;
        logic             bit_value;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] current_value;
        logic [FIELD_W-1:0] previous_value;
        logic [FIELD_W-1:0] fixed_mask;
        logic               selected_bit;
        logic               done_flag;
        logic               exhausted_flag;
        logic               accepted;
    } out_item_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

endpackage

>>> hw/rtl/masked_bit_vector_enumerator_top.sv
// top level: masked bit-vector enumerator
// an accepted item is captured in the item register, then executed to the output register
// a new item is accepted only in idle, after the previous one has executed; the execute
// step waits while the output register still holds an item that has not been taken
// reset: rst_n asynchronous active low; clears assignment, fixed bits, exhausted,
// start_value to 0 and active_width to 32
module masked_bit_vector_enumerator_top #(
    parameter int MAX_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mbve_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbve_pkg::FIELD_W-1:0]     cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  mbve_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mbve_pkg::out_item_t              out_item
);
    import mbve_pkg::*;

    localparam int DATA_W = (MAX_WIDTH < FIELD_W) ? MAX_WIDTH : FIELD_W;

    dp_cmd_t cmd;

    mbve_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    mbve_datapath #(
        .DATA_W (DATA_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .out_item  (out_item)
    );

endmodule

>>> hw/rtl/mbve_ctrl.sv
// controller: item handshake, execute sequencing and output register valid
module mbve_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output mbve_pkg::dp_cmd_t cmd
);
    import mbve_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter execute");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed item not presented");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_valid && !out_ready) |=>
            (state_reg == ST_EXEC && out_valid))
        else $error("execute advanced over a stalled output item");

    a_no_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !cmd.capture)
        else $error("capture during execute");

endmodule

>>> hw/rtl/mbve_datapath.sv
// datapath: configuration, enumerator state, operation logic and output register
module mbve_datapath #(
    parameter int DATA_W = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mbve_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbve_pkg::FIELD_W-1:0]     cfg_data,
    input  mbve_pkg::in_item_t               in_item,
    input  mbve_pkg::dp_cmd_t                cmd,
    output mbve_pkg::out_item_t              out_item
);
    import mbve_pkg::*;

    logic [FIELD_W-1:0] start_value_reg;
    logic [AW_W-1:0]    active_width_reg;
    logic [DATA_W-1:0]  asg_reg, asg_next;
    logic [DATA_W-1:0]  fix_reg, fix_next;
    logic               exh_reg, exh_next;
    in_item_t           item_reg;
    out_item_t          out_reg;

    logic [AW_W-1:0]    w;
    logic [DATA_W-1:0]  m, st, en, v, f, free, bit_m, low, region, x;
    logic [IDX_W-1:0]   pos;
    logic               inidx, cur, tgt, e, acc, conflict;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg  <= '0;
            active_width_reg <= AW_W'(32);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START_VALUE:  start_value_reg  <= cfg_data;
                CFG_ACTIVE_WIDTH: active_width_reg <= cfg_data[AW_W-1:0];
                default:          start_value_reg  <= start_value_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asg_reg <= '0;
            fix_reg <= '0;
            exh_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            asg_reg <= asg_next;
            fix_reg <= fix_next;
            exh_reg <= exh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
    end

    // effective width and masks
    always_comb
    begin
        if (active_width_reg == '0)
        begin
            w = AW_W'(1);
        end
        else if (active_width_reg > AW_W'(DATA_W))
        begin
            w = AW_W'(DATA_W);
        end
        else
        begin
            w = active_width_reg;
        end
        m     = {DATA_W{1'b1}} >> (AW_W'(DATA_W) - w);
        st    = start_value_reg[DATA_W-1:0] & m;
        en    = (st - DATA_W'(1)) & m;
        v     = asg_reg & m;
        f     = fix_reg & m;
        free  = ~f & m;
        inidx = {1'b0, item_reg.bit_index} < w;
        pos   = inidx ? IDX_W'(w - AW_W'(1) - {1'b0, item_reg.bit_index}) : '0;
        bit_m = inidx ? (DATA_W'(1) << pos) : '0;
        low   = inidx ? (bit_m - DATA_W'(1)) : '0;
        cur   = |(v & bit_m);
        e     = |(en & bit_m);
    end

    // operation
    always_comb
    begin
        asg_next = v;
        fix_next = f;
        exh_next = exh_reg;
        acc      = 1'b0;
        region   = '0;
        tgt      = 1'b0;
        conflict = 1'b0;
        x        = v | low | bit_m;
        unique case (item_reg.operation)
            OP_INC, OP_DEC:
            begin
                if (!exh_reg)
                begin
                    if (((v ^ en) & free) == '0)
                    begin
                        exh_next = 1'b1;
                    end
                    else
                    begin
                        if (item_reg.operation == OP_INC)
                        begin
                            asg_next = (((v | f) + DATA_W'(1)) & free) | (v & f);
                        end
                        else
                        begin
                            asg_next = (((v & free) - DATA_W'(1)) & free) | (v & f);
                        end
                        acc = 1'b1;
                    end
                end
            end
            OP_LEARN_FLIP, OP_LEARN_VALUE:
            begin
                if (item_reg.operation == OP_LEARN_FLIP)
                begin
                    conflict = |(f & bit_m);
                    tgt      = ~cur;
                end
                else
                begin
                    conflict = |(f & bit_m) && (cur != item_reg.bit_value);
                    tgt      = item_reg.bit_value;
                end
                if (!exh_reg && inidx && !conflict)
                begin
                    if (cur != tgt)
                    begin
                        priority if (tgt && e)
                        begin
                            asg_next = v & ~(low & free);
                        end
                        else if (tgt)
                        begin
                            asg_next = (v & ~(low & free)) | (st & low & free);
                        end
                        else if (e)
                        begin
                            asg_next = (v & ~free) | (st & free);
                        end
                        else
                        begin
                            asg_next = (((x | f) + DATA_W'(1)) & free) | (v & f);
                        end
                        if (tgt)
                        begin
                            asg_next = asg_next | bit_m;
                        end
                        else
                        begin
                            asg_next = asg_next & ~bit_m;
                        end
                    end
                    fix_next = f | bit_m;
                    acc      = 1'b1;
                end
            end
            OP_RESET_ALL, OP_RESET_RIGHT, OP_RESET_LEFT:
            begin
                if (item_reg.operation == OP_RESET_ALL)
                begin
                    region = m;
                end
                else if (item_reg.operation == OP_RESET_RIGHT)
                begin
                    region = inidx ? ((bit_m << 1) - DATA_W'(1)) : '0;
                end
                else
                begin
                    region = inidx ? (m & ~low) : m;
                end
                if (!exh_reg)
                begin
                    asg_next = (v & ~(region & free)) | (st & region & free);
                    acc      = 1'b1;
                end
            end
            OP_RESTART:
            begin
                fix_next = '0;
                exh_next = 1'b0;
                asg_next = st;
                acc      = 1'b1;
            end
            OP_READ:
            begin
                acc = !exh_reg;
            end
            default:
            begin
                acc = 1'b0;
            end
        endcase
        asg_next = asg_next & m;
        fix_next = fix_next & m;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg.current_value  <= FIELD_W'(asg_next);
            out_reg.previous_value <= FIELD_W'(v);
            out_reg.fixed_mask     <= FIELD_W'(fix_next);
            out_reg.selected_bit   <= inidx && |(asg_next & bit_m);
            out_reg.done_flag      <= ((asg_next ^ en) & ~fix_next & m) == '0;
            out_reg.exhausted_flag <= exh_next;
            out_reg.accepted       <= acc;
        end
    end

    assign out_item = out_reg;

endmodule
